[sv/qsort_pkg.sv]
// Shared constants and the sequencer state type of the quicksort array sorter.
package qsort_pkg;

   localparam int DATA_W = 32;
   localparam int MAX_ELEMENTS_DEF = 64;

   typedef enum logic [3:0] {
      S_LOAD,
      S_RD_MID,
      S_RD_HI,
      S_SW_HI,
      S_SCAN,
      S_SWAP_A,
      S_SWAP_B,
      S_FIN1,
      S_FIN2,
      S_FIN3,
      S_PUSH_H,
      S_POP,
      S_POP_WAIT,
      S_EMIT_RD,
      S_EMIT
   } state_type;

endpackage

[sv/qsort_ram.sv]
// Generic single-clock RAM: one write port, one read port, registered read data.
module qsort_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 64
) (
   input  logic                     clock,
   input  logic                     we,
   input  logic [$clog2(DEPTH)-1:0] waddr,
   input  logic [WIDTH-1:0]         wdata,
   input  logic [$clog2(DEPTH)-1:0] raddr,
   output logic [WIDTH-1:0]         rdata
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rdata_ff;

   always_ff @(posedge clock) begin
      if (we) begin
         mem_ff[waddr] <= wdata;
      end
      rdata_ff <= mem_ff[raddr];
   end

   assign rdata = rdata_ff;

endmodule

[sv/quicksort_array_sorter_unit.sv]
// Quicksort array sorter: collects a set of signed values, sorts them, streams them out.
//
// Values arrive one per req transfer and are written to the element memory; a
// transfer with req_tlast closes the set. Loading accepts one value per cycle. The
// set is then sorted in place by quicksort (middle element as pivot, pivot kept
// out of both halves, pending left partitions on a stack memory). Sorting time
// is set by the single read port of the element memory: each compare is a read in
// S_SCAN, each exchange during a scan adds S_SWAP_A and S_SWAP_B, and each partition
// adds setup (S_RD_MID, S_RD_HI, S_SW_HI) and finish (S_FIN1 to S_FIN3, S_PUSH_H,
// S_POP, S_POP_WAIT on a pop); an unlucky run of pivots makes it quadratic. The sorted
// values then leave at one per cycle while rsp_tready allows, after a first read in
// S_EMIT_RD, with rsp_tlast on the final one and rsp_tuser set on every result of
// a set that lost values beyond MAX_ELEMENTS. req_tready is low from the closing
// transfer until the final result has been loaded into the output register. No
// clearing pass follows reset.
module quicksort_array_sorter_unit #(
   parameter int MAX_ELEMENTS = qsort_pkg::MAX_ELEMENTS_DEF
) (
   input  logic                                clock,
   input  logic                                reset,
   // req_tdata: value[31:0]
   input  logic signed [qsort_pkg::DATA_W-1:0] req_tdata,
   input  logic                                req_tlast,  // last
   input  logic                                req_tvalid,
   output logic                                req_tready,
   // rsp_tdata: sorted_value[31:0]
   output logic signed [qsort_pkg::DATA_W-1:0] rsp_tdata,
   output logic                                rsp_tlast,  // final_res
   output logic                                rsp_tuser,  // dropped
   output logic                                rsp_tvalid,
   input  logic                                rsp_tready
);

   localparam int IDX_W = $clog2(MAX_ELEMENTS);
   localparam int CNT_W = $clog2(MAX_ELEMENTS + 1);
   localparam int DW    = qsort_pkg::DATA_W;

   qsort_pkg::state_type state_ff, state_in;

   logic [CNT_W-1:0] count_ff, count_in;
   logic             ovf_ff, ovf_in;
   logic [IDX_W-1:0] lo_ff, lo_in, hi_ff, hi_in;
   logic [IDX_W-1:0] i_ff, i_in, s_ff, s_in;
   logic [IDX_W-1:0] sp_ff, sp_in, k_ff, k_in;
   logic [DW-1:0]    pivot_ff, pivot_in, vi_ff, vi_in, vs_ff, vs_in;
   logic             out_valid_ff, out_valid_in, out_last_ff, out_last_in;
   logic             out_user_ff, out_user_in;
   logic [DW-1:0]    out_data_ff, out_data_in;

   logic               mem_we;
   logic [IDX_W-1:0]   mem_waddr, mem_raddr;
   logic [DW-1:0]      mem_wdata, mem_rdata;
   logic               stk_we;
   logic [IDX_W-1:0]   stk_waddr, stk_raddr;
   logic [2*IDX_W-1:0] stk_wdata, stk_rdata;

   logic             accept, full, le, last_i, swap_needed, emit_last, load_ok;
   logic             push_lo, go_hi;
   logic [CNT_W-1:0] n_close;
   logic [IDX_W:0]   span;
   logic [IDX_W-1:0] mid;

   assign accept      = req_tvalid && req_tready;
   assign full        = (count_ff == CNT_W'(MAX_ELEMENTS));
   assign n_close     = full ? count_ff : count_ff + CNT_W'(1);
   assign span        = {1'b0, hi_ff} - {1'b0, lo_ff} + (IDX_W+1)'(1);
   assign mid         = lo_ff + IDX_W'(span >> 1);
   assign le          = ($signed(mem_rdata) <= $signed(pivot_ff));
   assign swap_needed = le && (s_ff != i_ff);
   assign last_i      = (i_ff == hi_ff - IDX_W'(1));
   assign push_lo     = ({1'b0, s_ff} > ({1'b0, lo_ff} + (IDX_W+1)'(1)));
   assign go_hi       = ({1'b0, hi_ff} > ({1'b0, s_ff} + (IDX_W+1)'(1)));
   assign emit_last   = ((CNT_W'(k_ff) + CNT_W'(1)) == count_ff);
   assign load_ok     = !out_valid_ff || rsp_tready;

   qsort_ram #(.WIDTH(DW), .DEPTH(MAX_ELEMENTS)) u_elem_ram (
      .clock (clock),
      .we    (mem_we),
      .waddr (mem_waddr),
      .wdata (mem_wdata),
      .raddr (mem_raddr),
      .rdata (mem_rdata)
   );

   // pending partitions: {hi, lo}
   qsort_ram #(.WIDTH(2*IDX_W), .DEPTH(MAX_ELEMENTS)) u_stack_ram (
      .clock (clock),
      .we    (stk_we),
      .waddr (stk_waddr),
      .wdata (stk_wdata),
      .raddr (stk_raddr),
      .rdata (stk_rdata)
   );

   // next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         qsort_pkg::S_LOAD: begin
            if (accept && req_tlast) begin
               state_in = (n_close < CNT_W'(2)) ? qsort_pkg::S_EMIT_RD : qsort_pkg::S_RD_MID;
            end
         end
         qsort_pkg::S_RD_MID:   state_in = qsort_pkg::S_RD_HI;
         qsort_pkg::S_RD_HI:    state_in = qsort_pkg::S_SW_HI;
         qsort_pkg::S_SW_HI:    state_in = qsort_pkg::S_SCAN;
         qsort_pkg::S_SCAN: begin
            if (swap_needed) begin
               state_in = qsort_pkg::S_SWAP_A;
            end else if (last_i) begin
               state_in = qsort_pkg::S_FIN1;
            end
         end
         qsort_pkg::S_SWAP_A:   state_in = qsort_pkg::S_SWAP_B;
         qsort_pkg::S_SWAP_B:   state_in = last_i ? qsort_pkg::S_FIN1 : qsort_pkg::S_SCAN;
         qsort_pkg::S_FIN1:     state_in = qsort_pkg::S_FIN2;
         qsort_pkg::S_FIN2:     state_in = qsort_pkg::S_FIN3;
         qsort_pkg::S_FIN3:     state_in = qsort_pkg::S_PUSH_H;
         qsort_pkg::S_PUSH_H:   state_in = go_hi ? qsort_pkg::S_RD_MID : qsort_pkg::S_POP;
         qsort_pkg::S_POP: begin
            state_in = (sp_ff == '0) ? qsort_pkg::S_EMIT_RD : qsort_pkg::S_POP_WAIT;
         end
         qsort_pkg::S_POP_WAIT: state_in = qsort_pkg::S_RD_MID;
         qsort_pkg::S_EMIT_RD:  state_in = qsort_pkg::S_EMIT;
         qsort_pkg::S_EMIT: begin
            if (load_ok && emit_last) begin
               state_in = qsort_pkg::S_LOAD;
            end
         end
         default:               state_in = qsort_pkg::S_LOAD;
      endcase
   end

   // datapath and memory control
   always_comb begin
      req_tready   = 1'b0;
      mem_we       = 1'b0;
      mem_waddr    = i_ff;
      mem_wdata    = vs_ff;
      mem_raddr    = i_ff;
      stk_we       = 1'b0;
      stk_waddr    = sp_ff;
      stk_wdata    = {s_ff - IDX_W'(1), lo_ff};
      stk_raddr    = sp_ff - IDX_W'(1);
      count_in     = count_ff;
      ovf_in       = ovf_ff;
      lo_in        = lo_ff;
      hi_in        = hi_ff;
      i_in         = i_ff;
      s_in         = s_ff;
      sp_in        = sp_ff;
      k_in         = k_ff;
      pivot_in     = pivot_ff;
      vi_in        = vi_ff;
      vs_in        = vs_ff;
      out_valid_in = out_valid_ff && !rsp_tready;
      out_data_in  = out_data_ff;
      out_last_in  = out_last_ff;
      out_user_in  = out_user_ff;
      case (state_ff)
         qsort_pkg::S_LOAD: begin
            req_tready = 1'b1;
            lo_in      = '0;
            hi_in      = IDX_W'(n_close - CNT_W'(1));
            sp_in      = '0;
            k_in       = '0;
            if (accept) begin
               if (!full) begin
                  mem_we    = 1'b1;
                  mem_waddr = IDX_W'(count_ff);
                  mem_wdata = req_tdata;
                  count_in  = count_ff + CNT_W'(1);
               end else begin
                  ovf_in = 1'b1;
               end
            end
         end
         qsort_pkg::S_RD_MID: begin
            mem_raddr = mid;
         end
         qsort_pkg::S_RD_HI: begin
            mem_raddr = hi_ff;
            pivot_in  = mem_rdata;
         end
         qsort_pkg::S_SW_HI: begin
            // element at hi moves to mid; the pivot stays in a register until the finish
            mem_we    = 1'b1;
            mem_waddr = mid;
            mem_wdata = mem_rdata;
            mem_raddr = lo_ff;
            i_in      = lo_ff;
            s_in      = lo_ff;
         end
         qsort_pkg::S_SCAN: begin
            if (swap_needed) begin
               vi_in     = mem_rdata;
               mem_raddr = s_ff;
            end else begin
               if (le) begin
                  s_in = s_ff + IDX_W'(1);
               end
               if (!last_i) begin
                  i_in      = i_ff + IDX_W'(1);
                  mem_raddr = i_ff + IDX_W'(1);
               end
            end
         end
         qsort_pkg::S_SWAP_A: begin
            mem_we    = 1'b1;
            mem_waddr = s_ff;
            mem_wdata = vi_ff;
            vs_in     = mem_rdata;
         end
         qsort_pkg::S_SWAP_B: begin
            mem_we    = 1'b1;
            mem_waddr = i_ff;
            mem_wdata = vs_ff;
            s_in      = s_ff + IDX_W'(1);
            if (!last_i) begin
               i_in      = i_ff + IDX_W'(1);
               mem_raddr = i_ff + IDX_W'(1);
            end
         end
         qsort_pkg::S_FIN1: begin
            mem_raddr = s_ff;
         end
         qsort_pkg::S_FIN2: begin
            mem_we    = 1'b1;
            mem_waddr = hi_ff;
            mem_wdata = mem_rdata;
         end
         qsort_pkg::S_FIN3: begin
            mem_we    = 1'b1;
            mem_waddr = s_ff;
            mem_wdata = pivot_ff;
            if (push_lo) begin
               stk_we = 1'b1;
               sp_in  = sp_ff + IDX_W'(1);
            end
         end
         qsort_pkg::S_PUSH_H: begin
            // the upper part goes on directly, without a trip through the stack
            if (go_hi) begin
               lo_in = s_ff + IDX_W'(1);
            end
         end
         qsort_pkg::S_POP: begin
            if (sp_ff != '0) begin
               sp_in = sp_ff - IDX_W'(1);
            end
         end
         qsort_pkg::S_POP_WAIT: begin
            lo_in = stk_rdata[IDX_W-1:0];
            hi_in = stk_rdata[2*IDX_W-1:IDX_W];
         end
         qsort_pkg::S_EMIT_RD: begin
            mem_raddr = k_ff;
         end
         qsort_pkg::S_EMIT: begin
            mem_raddr = k_ff;
            if (load_ok) begin
               out_valid_in = 1'b1;
               out_data_in  = mem_rdata;
               out_last_in  = emit_last;
               out_user_in  = ovf_ff;
               if (emit_last) begin
                  count_in = '0;
                  ovf_in   = 1'b0;
               end else begin
                  k_in      = k_ff + IDX_W'(1);
                  mem_raddr = k_ff + IDX_W'(1);
               end
            end
         end
         default: begin
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= qsort_pkg::S_LOAD;
         count_ff     <= '0;
         ovf_ff       <= 1'b0;
         sp_ff        <= '0;
         out_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         count_ff     <= count_in;
         ovf_ff       <= ovf_in;
         sp_ff        <= sp_in;
         out_valid_ff <= out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      lo_ff       <= lo_in;
      hi_ff       <= hi_in;
      i_ff        <= i_in;
      s_ff        <= s_in;
      k_ff        <= k_in;
      pivot_ff    <= pivot_in;
      vi_ff       <= vi_in;
      vs_ff       <= vs_in;
      out_data_ff <= out_data_in;
      out_last_ff <= out_last_in;
      out_user_ff <= out_user_in;
   end

   assign rsp_tvalid = out_valid_ff;
   assign rsp_tdata  = out_data_ff;
   assign rsp_tlast  = out_last_ff;
   assign rsp_tuser  = out_user_ff;

endmodule

[sv/qsort_chk.sv]
// Port-level checker for the quicksort array sorter, bound to the top level.
module qsort_chk (
   input logic                         clock,
   input logic                         reset,
   input logic                         req_tlast,
   input logic                         req_tvalid,
   input logic                         req_tready,
   input logic [qsort_pkg::DATA_W-1:0] rsp_tdata,
   input logic                         rsp_tlast,
   input logic                         rsp_tuser,
   input logic                         rsp_tvalid,
   input logic                         rsp_tready
);

   logic       req_xfer, rsp_xfer;
   logic [1:0] owed_ff, owed_in;
   logic       mid_set_ff, user_seen_ff;

   assign req_xfer = req_tvalid && req_tready;
   assign rsp_xfer = rsp_tvalid && rsp_tready;

   // sets closed on the input side whose final result has not yet left
   always_comb begin
      owed_in = owed_ff;
      if (req_xfer && req_tlast && !(rsp_xfer && rsp_tlast)) begin
         owed_in = owed_ff + 2'd1;
      end else if (!(req_xfer && req_tlast) && rsp_xfer && rsp_tlast) begin
         owed_in = owed_ff - 2'd1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         owed_ff    <= '0;
         mid_set_ff <= 1'b0;
      end else begin
         owed_ff <= owed_in;
         if (rsp_xfer) begin
            mid_set_ff <= !rsp_tlast;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (rsp_xfer) begin
         user_seen_ff <= rsp_tuser;
      end
   end

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata)
         && $stable(rsp_tlast) && $stable(rsp_tuser))
      else $error("result changed while stalled");

   a_busy_after_close: assert property (@(posedge clock) disable iff (reset)
      req_xfer && req_tlast |=> !req_tready)
      else $error("input taken right after a closing transfer");

   a_no_unowed_result: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> owed_ff != 2'd0)
      else $error("result without a closed set");

   a_dropped_steady: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && mid_set_ff |-> rsp_tuser == user_seen_ff)
      else $error("dropped flag changed within a set");

endmodule

bind quicksort_array_sorter_unit qsort_chk u_qsort_chk (.*);

[dv/testbench.sv]
// Self-checking testbench for the quicksort array sorter: directed table plus random sets.
module testbench;

   typedef struct packed {
      logic signed [qsort_pkg::DATA_W-1:0] value;
      logic                                is_last;
      logic                                dropped;
   } sorted_entry_type;

   typedef struct {
      logic signed [qsort_pkg::DATA_W-1:0] value;
      bit                                  last;
      bit                                  typed;
      sorted_entry_type                    exp;
   } stim_row_type;

   typedef enum {FILL_WIDE, FILL_NARROW, FILL_ASCEND, FILL_DESCEND, FILL_EXTREME} fill_style_type;
   typedef enum {MODE_SENDER_GAPS, MODE_RECEIVER_GAPS, MODE_STEADY} traffic_mode_type;

   localparam int SET_CAPACITY = qsort_pkg::MAX_ELEMENTS_DEF;
   localparam int RANDOM_ITEMS = 73;
   localparam int LONG_HOLD_CYCLES = 600;
   localparam int DRAIN_CYCLES = 100;

   logic                                clock;
   logic                                reset;
   logic signed [qsort_pkg::DATA_W-1:0] req_tdata;
   logic                                req_tlast;
   logic                                req_tvalid;
   logic                                req_tready;
   logic signed [qsort_pkg::DATA_W-1:0] rsp_tdata;
   logic                                rsp_tlast;
   logic                                rsp_tuser;
   logic                                rsp_tvalid;
   logic                                rsp_tready;

   quicksort_array_sorter_unit DUT (
      .clock      (clock),
      .reset      (reset),
      .req_tdata  (req_tdata),
      .req_tlast  (req_tlast),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tlast  (rsp_tlast),
      .rsp_tuser  (rsp_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready)
   );

   // set under construction in the predictor, and sorted values still owed by the block
   logic signed [qsort_pkg::DATA_W-1:0] open_set[$];
   bit                                  set_overflow;
   sorted_entry_type                    pending_sorted[$];
   traffic_mode_type                    traffic_mode;
   int                                  error_count;
   int                                  random_items;

   // single-element sets have their result typed in; the rest go through the predictor
   stim_row_type directed_rows [0:17] = '{
      '{32'sh7FFFFFFF, 1'b1, 1'b1, '{32'sh7FFFFFFF, 1'b1, 1'b0}},
      '{32'sh80000000, 1'b1, 1'b1, '{32'sh80000000, 1'b1, 1'b0}},
      '{32'sh00000000, 1'b1, 1'b1, '{32'sh00000000, 1'b1, 1'b0}},
      '{32'shFFFFFFFF, 1'b1, 1'b1, '{32'shFFFFFFFF, 1'b1, 1'b0}},
      '{32'sd5,        1'b0, 1'b0, '0},
      '{-32'sd3,       1'b0, 1'b0, '0},
      '{32'sd5,        1'b0, 1'b0, '0},
      '{32'sh80000000, 1'b0, 1'b0, '0},
      '{32'sh7FFFFFFF, 1'b1, 1'b0, '0},
      '{32'sd42,       1'b0, 1'b0, '0},
      '{32'sd42,       1'b0, 1'b0, '0},
      '{32'sd42,       1'b0, 1'b0, '0},
      '{32'sd42,       1'b1, 1'b0, '0},
      '{32'sd9,        1'b0, 1'b0, '0},
      '{-32'sd9,       1'b1, 1'b0, '0},
      '{32'sd100,      1'b0, 1'b0, '0},
      '{32'sd200,      1'b0, 1'b0, '0},
      '{32'sd300,      1'b1, 1'b0, '0}
   };

   function automatic int gap_percent(traffic_mode_type mode, bit receiver_side);
      case (mode)
         MODE_SENDER_GAPS:   return receiver_side ? 65 : 16;
         MODE_RECEIVER_GAPS: return receiver_side ? 16 : 65;
         default:            return 0;
      endcase
   endfunction

   // Predictor: stores the element (or notes the overflow); on a closing element
   // sorts the set ascending and appends one entry per stored element.
   function automatic void absorb_element(logic signed [qsort_pkg::DATA_W-1:0] value,
                                          bit last, bit typed,
                                          sorted_entry_type typed_exp);
      logic signed [qsort_pkg::DATA_W-1:0] key;
      sorted_entry_type                    entry;
      int                                  j;
      int                                  n;
      if (open_set.size() < SET_CAPACITY)
         open_set.push_back(value);
      else
         set_overflow = 1'b1;
      if (!last)
         return;
      n = open_set.size();
      for (int i = 1; i < n; i++) begin
         key = open_set[i];
         j = i - 1;
         while (j >= 0 && open_set[j] > key) begin
            open_set[j + 1] = open_set[j];
            j--;
         end
         open_set[j + 1] = key;
      end
      if (typed) begin
         pending_sorted.push_back(typed_exp);
      end else begin
         for (int k = 0; k < n; k++) begin
            entry.value   = open_set[k];
            entry.is_last = (k == n - 1);
            entry.dropped = set_overflow;
            pending_sorted.push_back(entry);
         end
      end
      open_set.delete();
      set_overflow = 1'b0;
   endfunction

   task automatic push_element(logic signed [qsort_pkg::DATA_W-1:0] value, bit last,
                               bit typed, sorted_entry_type typed_exp);
      while ($urandom_range(99) < gap_percent(traffic_mode, 1'b0)) begin
         req_tvalid <= 1'b0;
         @(posedge clock);
      end
      req_tdata  <= value;
      req_tlast  <= last;
      req_tvalid <= 1'b1;
      @(posedge clock);
      while (!req_tready)
         @(posedge clock);
      absorb_element(value, last, typed, typed_exp);
   endtask

   task automatic run_set(int n, fill_style_type style);
      logic signed [qsort_pkg::DATA_W-1:0] value;
      logic signed [qsort_pkg::DATA_W-1:0] base;
      logic signed [qsort_pkg::DATA_W-1:0] step;
      base = $urandom;
      step = $urandom_range(1, 1000);
      for (int i = 0; i < n; i++) begin
         case (style)
            FILL_WIDE:    value = $urandom;
            FILL_NARROW:  value = $signed($urandom_range(8)) - 4;
            FILL_ASCEND:  value = base + i * step;
            FILL_DESCEND: value = base - i * step;
            default: begin
               case ($urandom_range(4))
                  0:       value = 32'sh80000000;
                  1:       value = 32'sh7FFFFFFF;
                  2:       value = 32'sh00000000;
                  3:       value = 32'shFFFFFFFF;
                  default: value = 32'sh00000001;
               endcase
            end
         endcase
         push_element(value, i == n - 1, 1'b0, '0);
      end
      random_items += n;
   endtask

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   initial begin
      #3000000;
      $display("[FAIL] regression broken");
      $finish;
   end

   // Receiver: checks each result transfer, stalls at random, and once holds off
   // for a long stretch when steady traffic starts so the block backs up.
   initial begin
      int  hold_left;
      bit  hold_done;
      sorted_entry_type exp;
      hold_left = 0;
      hold_done = 1'b0;
      rsp_tready = 1'b0;
      forever begin
         @(posedge clock);
         if (!reset && rsp_tvalid && rsp_tready) begin
            if (pending_sorted.size() == 0) begin
               $display("%0t: unexpected result: expected none, got value %0d last %b dropped %b",
                        $time, rsp_tdata, rsp_tlast, rsp_tuser);
               error_count++;
            end else begin
               exp = pending_sorted.pop_front();
               if (rsp_tdata !== exp.value) begin
                  $display("%0t: sorted value mismatch: expected %0d, got %0d",
                           $time, exp.value, rsp_tdata);
                  error_count++;
               end
               if (rsp_tlast !== exp.is_last) begin
                  $display("%0t: tlast mismatch: expected %b, got %b",
                           $time, exp.is_last, rsp_tlast);
                  error_count++;
               end
               if (rsp_tuser !== exp.dropped) begin
                  $display("%0t: dropped flag mismatch: expected %b, got %b",
                           $time, exp.dropped, rsp_tuser);
                  error_count++;
               end
            end
         end
         if (hold_left > 0) begin
            hold_left--;
            rsp_tready <= 1'b0;
         end else if (traffic_mode == MODE_STEADY && !hold_done) begin
            hold_done = 1'b1;
            hold_left = LONG_HOLD_CYCLES;
            rsp_tready <= 1'b0;
         end else begin
            rsp_tready <= ($urandom_range(99) >= gap_percent(traffic_mode, 1'b1));
         end
      end
   end

   // Sender: reset, directed table, full and overfull sets, then random sets.
   initial begin
      req_tvalid   = 1'b0;
      req_tdata    = '0;
      req_tlast    = 1'b0;
      reset        = 1'b1;
      set_overflow = 1'b0;
      error_count  = 0;
      random_items = 0;
      traffic_mode = MODE_SENDER_GAPS;
      repeat (12) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      foreach (directed_rows[r])
         push_element(directed_rows[r].value, directed_rows[r].last,
                      directed_rows[r].typed, directed_rows[r].exp);

      // exactly full, then closing element dropped
      run_set(SET_CAPACITY, FILL_WIDE);
      run_set(SET_CAPACITY + 1, FILL_NARROW);
      random_items = 0;

      while (random_items < RANDOM_ITEMS) begin
         if (random_items >= 2 * RANDOM_ITEMS / 3)
            traffic_mode = MODE_STEADY;
         else if (random_items >= RANDOM_ITEMS / 3)
            traffic_mode = MODE_RECEIVER_GAPS;
         run_set($urandom_range(1, 12), fill_style_type'($urandom_range(4)));
      end

      req_tvalid <= 1'b0;
      while (pending_sorted.size() != 0)
         @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (error_count == 0)
         $display("[ OK ] regression clean");
      else
         $display("[FAIL] regression broken");
      $finish;
   end

endmodule

[filelist.f]
sv/qsort_pkg.sv
sv/qsort_ram.sv
sv/quicksort_array_sorter_unit.sv
sv/qsort_chk.sv
dv/testbench.sv
